// ===== hw/rtl/crtc_pkg.sv =====
// shared types, bus function codes and burst tables for the crt controller port
// no dependencies
`default_nettype none

package crtc_pkg;

  localparam int MAX_CHARS_PER_ROW_DEF = 80;

  localparam logic [1:0] FUNC_WR_CMD   = 2'd0;
  localparam logic [1:0] FUNC_WR_PARAM = 2'd1;
  localparam logic [1:0] FUNC_RD_STAT  = 2'd2;
  localparam logic [1:0] FUNC_RD_PARAM = 2'd3;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] data_byte;
  } crtc_in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [7:0]  status_now;
    logic        display_on;
    logic        interrupt_on;
    logic [6:0]  chars_per_row;
    logic [6:0]  rows_per_frame;
    logic [4:0]  lines_per_row;
    logic [3:0]  underline_line;
    logic [14:0] cursor_address;
    logic [5:0]  burst_space;
    logic [3:0]  burst_count;
    logic [10:0] format_bits;
  } crtc_out_t;

  // character clocks between dma bursts
  function automatic logic [5:0] burst_space_lookup(input logic [2:0] code);
    logic [5:0] r;
    case (code)
      3'd0:    r = 6'd0;
      3'd1:    r = 6'd7;
      3'd2:    r = 6'd15;
      3'd3:    r = 6'd23;
      3'd4:    r = 6'd31;
      3'd5:    r = 6'd39;
      3'd6:    r = 6'd47;
      default: r = 6'd55;
    endcase
    return r;
  endfunction

  // dma cycles per burst
  function automatic logic [3:0] burst_count_lookup(input logic [1:0] code);
    logic [3:0] r;
    case (code)
      2'd0:    r = 4'd1;
      2'd1:    r = 4'd2;
      2'd2:    r = 4'd4;
      default: r = 4'd8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crtc_in_reg.sv =====
// input holding register for bus access transfers
// depends on crtc_pkg
`default_nettype none

module crtc_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire crtc_pkg::crtc_in_t in_data,
  output logic                   in_stall,
  input  wire logic              take,
  output logic                   hold_valid,
  output crtc_pkg::crtc_in_t     hold_data
);
  import crtc_pkg::*;

  logic     valid_r, valid_nxt;
  crtc_in_t data_r;
  logic     accept;

  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/crtc_core.sv =====
// command decode, parameter sequencing and format registers
// depends on crtc_pkg
`default_nettype none

module crtc_core #(
  parameter int MAX_CHARS_PER_ROW = crtc_pkg::MAX_CHARS_PER_ROW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire crtc_pkg::crtc_in_t item,
  output crtc_pkg::crtc_out_t    res_nxt
);
  import crtc_pkg::*;

  typedef enum logic [1:0] {PC_NONE, PC_RESET, PC_PEN, PC_CURSOR} pend_t;

  localparam logic [7:0] CMD_RESET  = 8'h00;
  localparam logic [7:0] CMD_STOP   = 8'h40;
  localparam logic [7:0] CMD_PEN    = 8'h60;
  localparam logic [7:0] CMD_CURSOR = 8'h80;
  localparam logic [2:0] GRP_START  = 3'b001;
  localparam logic [3:0] GRP_INT_EN = 4'ha;
  localparam logic [3:0] GRP_INT_DI = 4'hc;
  localparam logic [7:0] ST_IMPROPER = 8'h08;
  localparam logic [7:0] ST_KEEP     = 8'hc4;
  localparam logic [7:0] ST_START    = 8'h44;
  localparam logic [7:0] ST_CLR_IE   = 8'hbf;
  localparam logic [7:0] ST_CLR_VE   = 8'hfb;
  localparam int         CLAMP_I     = (MAX_CHARS_PER_ROW < 127) ? MAX_CHARS_PER_ROW : 127;
  localparam logic [7:0] CLAMP       = 8'(CLAMP_I);

  logic [7:0]  status_r, status_nxt;
  pend_t       pend_r, pend_nxt;
  logic [2:0]  left_r, left_nxt;
  logic        disp_r, disp_nxt;
  logic        int_r, int_nxt;
  logic [6:0]  chars_r, chars_nxt;
  logic [6:0]  rows_r, rows_nxt;
  logic [4:0]  lines_r, lines_nxt;
  logic [3:0]  under_r, under_nxt;
  logic [10:0] mode_r, mode_nxt;
  logic [7:0]  ccol_r, ccol_nxt;
  logic [7:0]  crow_r, crow_nxt;
  logic [5:0]  gap_r, gap_nxt;
  logic [3:0]  blen_r, blen_nxt;
  logic [7:0]  rd;
  logic [7:0]  n;
  logic [7:0]  v;

  assign v = item.data_byte;

  always_comb begin
    status_nxt = status_r;
    pend_nxt   = pend_r;
    left_nxt   = left_r;
    disp_nxt   = disp_r;
    int_nxt    = int_r;
    chars_nxt  = chars_r;
    rows_nxt   = rows_r;
    lines_nxt  = lines_r;
    under_nxt  = under_r;
    mode_nxt   = mode_r;
    ccol_nxt   = ccol_r;
    crow_nxt   = crow_r;
    gap_nxt    = gap_r;
    blen_nxt   = blen_r;
    rd         = 8'd0;
    n          = {1'b0, v[6:0]} + 8'd1;
    if (n > CLAMP) begin
      n = CLAMP;
    end
    case (item.func)
      FUNC_WR_CMD: begin
        if (left_r != 3'd0) begin
          status_nxt = status_nxt | ST_IMPROPER;
        end
        left_nxt = 3'd0;
        pend_nxt = PC_NONE;
        if (v == CMD_RESET) begin
          pend_nxt   = PC_RESET;
          left_nxt   = 3'd4;
          status_nxt = status_nxt & ST_CLR_IE;
        end else if (v == CMD_STOP) begin
          disp_nxt   = 1'b0;
          status_nxt = status_nxt & ST_CLR_VE;
        end else if (v == CMD_PEN) begin
          pend_nxt = PC_PEN;
          left_nxt = 3'd2;
        end else if (v == CMD_CURSOR) begin
          pend_nxt = PC_CURSOR;
          left_nxt = 3'd2;
        end else if (v[7:5] == GRP_START) begin
          disp_nxt   = 1'b1;
          gap_nxt    = burst_space_lookup(v[4:2]);
          blen_nxt   = burst_count_lookup(v[1:0]);
          status_nxt = status_nxt | ST_START;
        end else if (v[7:4] == GRP_INT_EN) begin
          int_nxt = 1'b1;
        end else if (v[7:4] == GRP_INT_DI) begin
          int_nxt = 1'b0;
        end
      end
      FUNC_WR_PARAM: begin
        if (pend_r == PC_NONE) begin
          status_nxt = status_r | ST_IMPROPER;
        end else begin
          if (pend_r == PC_RESET) begin
            case (left_r)
              3'd4: begin
                chars_nxt = n[6:0];
                mode_nxt  = {v[7], mode_r[9:0]};
              end
              3'd3: begin
                mode_nxt[5:4] = v[7:6];
                rows_nxt      = {1'b0, v[5:0]} + 7'd1;
              end
              3'd2: begin
                under_nxt = v[7:4];
                lines_nxt = {1'b0, v[3:0]} + 5'd1;
              end
              3'd1: begin
                // fourth reset parameter rebuilds all but spacing and vrows
                mode_nxt = {mode_r[10], v[3:0], mode_r[5:4], !v[5], v[4], v[6], v[7]};
              end
              default: ;
            endcase
          end else if (pend_r == PC_CURSOR) begin
            if (left_r == 3'd2) begin
              ccol_nxt = v;
            end else if (left_r == 3'd1) begin
              crow_nxt = v;
            end
          end
          if (left_r == 3'd0) begin
            status_nxt = status_r | ST_IMPROPER;
          end else begin
            left_nxt = left_r - 3'd1;
          end
        end
      end
      FUNC_RD_STAT: begin
        rd         = status_r;
        status_nxt = status_r & ST_KEEP;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= 8'd0;
      pend_r   <= PC_NONE;
      left_r   <= 3'd0;
      disp_r   <= 1'b0;
      int_r    <= 1'b0;
      chars_r  <= 7'd80;
      rows_r   <= 7'd25;
      lines_r  <= 5'd10;
      under_r  <= 4'd0;
      mode_r   <= 11'd1;
      ccol_r   <= 8'd0;
      crow_r   <= 8'd0;
      gap_r    <= 6'd0;
      blen_r   <= 4'd8;
    end else if (fire) begin
      status_r <= status_nxt;
      pend_r   <= pend_nxt;
      left_r   <= left_nxt;
      disp_r   <= disp_nxt;
      int_r    <= int_nxt;
      chars_r  <= chars_nxt;
      rows_r   <= rows_nxt;
      lines_r  <= lines_nxt;
      under_r  <= under_nxt;
      mode_r   <= mode_nxt;
      ccol_r   <= ccol_nxt;
      crow_r   <= crow_nxt;
      gap_r    <= gap_nxt;
      blen_r   <= blen_nxt;
    end
  end

  always_comb begin
    res_nxt.read_data      = rd;
    res_nxt.status_now     = status_nxt;
    res_nxt.display_on     = disp_nxt;
    res_nxt.interrupt_on   = int_nxt;
    res_nxt.chars_per_row  = chars_nxt;
    res_nxt.rows_per_frame = rows_nxt;
    res_nxt.lines_per_row  = lines_nxt;
    res_nxt.underline_line = under_nxt;
    // row * 80 as two shifted copies
    res_nxt.cursor_address = {7'd0, ccol_nxt} + {1'b0, crow_nxt, 6'd0}
                           + {3'd0, crow_nxt, 4'd0};
    res_nxt.burst_space    = gap_nxt;
    res_nxt.burst_count    = blen_nxt;
    res_nxt.format_bits    = mode_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/crtc_command_parameter_port.sv =====
// top level of the crt controller command, parameter and status port
// depends on crtc_pkg, crtc_in_reg and crtc_core
//
// Each input transfer is one bus access (command write, parameter write, status
// read or parameter read) and produces exactly one result transfer carrying the
// read byte and a snapshot of the status and format registers after the access.
// Throughput is one access per clock while the output is not stalled: an access sits in the
// input register, and the decode logic updates the controller state as it moves into the result
// register, so each access passes through the input register and then the result register
// before its result transfers.
// The input side keeps taking transfers while a result waits, as long as the
// result register is being drained; a stalled output backs up through one held
// access before in_stall rises.
`default_nettype none

module crtc_command_parameter_port #(
  parameter int MAX_CHARS_PER_ROW = crtc_pkg::MAX_CHARS_PER_ROW_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire crtc_pkg::crtc_in_t in_data,
  output logic                   in_stall,
  output logic                   out_valid,
  output crtc_pkg::crtc_out_t    out_data,
  input  wire logic              out_stall
);
  import crtc_pkg::*;

  // input stage
  logic      hold_valid;
  crtc_in_t  hold_data;
  logic      advance;

  // result stage
  logic      out_valid_r, out_valid_nxt;
  crtc_out_t out_data_r;
  crtc_out_t res_nxt;

  // access moves on when the result register is empty or being taken
  assign advance = hold_valid && (!out_valid_r || !out_stall);

  crtc_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .in_stall   (in_stall),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  // state update happens exactly once per access, on the move into the result
  crtc_core #(
    .MAX_CHARS_PER_ROW (MAX_CHARS_PER_ROW)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (advance),
    .item    (hold_data),
    .res_nxt (res_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // result register, payload loads without reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input only backs up when a result is held against a stall
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // a blocked result must not be overwritten by a new access
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("held result dropped");

  // row width stays within the clamp
  a_chars_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.chars_per_row != 7'd0 &&
                   32'(out_data.chars_per_row) <= MAX_CHARS_PER_ROW))
    else $error("characters per row out of range");

  // burst length is always a power of two
  a_burst_pow2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_data.burst_count))
    else $error("burst count not a power of two");

endmodule

`default_nettype wire

// ===== bench/crtc_tb_pkg.sv =====
// command byte codes shared by the crt controller port bench
// no dependencies
package crtc_tb_pkg;

  localparam logic [7:0] CMD_RESET           = 8'h00;
  localparam logic [7:0] CMD_START           = 8'h20;
  localparam logic [7:0] CMD_STOP            = 8'h40;
  localparam logic [7:0] CMD_LIGHT_PEN       = 8'h60;
  localparam logic [7:0] CMD_LOAD_CURSOR     = 8'h80;
  localparam logic [7:0] CMD_INT_EN          = 8'ha0;
  localparam logic [7:0] CMD_INT_DIS         = 8'hc0;
  localparam logic [7:0] CMD_PRESET_COUNTERS = 8'he0;

  localparam logic [7:0] CMD_START_MASK      = 8'he0;
  localparam logic [7:0] CMD_INT_MASK        = 8'hf0;

endpackage

// ===== bench/crtc_port_checker.sv =====
// watches both channels of the crt controller port, predicts each result and compares
// depends on crtc_pkg and crtc_tb_pkg
module crtc_port_checker #(
  parameter int MAX_CHARS_PER_ROW = crtc_pkg::MAX_CHARS_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  crtc_pkg::crtc_in_t  in_data,
  input  logic                in_stall,
  input  logic                out_valid,
  input  crtc_pkg::crtc_out_t out_data,
  input  logic                out_stall,
  output int                  mismatch_count,
  output int                  results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import crtc_pkg::*;
  import crtc_tb_pkg::*;

  typedef enum logic [1:0] {
    OWED_NONE,
    OWED_RESET,
    OWED_PEN,
    OWED_CURSOR
  } owed_cmd_t;

  localparam logic [7:0] STAT_IE       = 8'h40;
  localparam logic [7:0] STAT_IMPROPER = 8'h08;
  localparam logic [7:0] STAT_VE       = 8'h04;
  localparam logic [7:0] STAT_KEEP     = 8'hc4;

  // predicted controller state
  logic [7:0]  status;
  owed_cmd_t   owed_cmd;
  logic [2:0]  params_owed;
  logic        video_on;
  logic        irq_on;
  logic [6:0]  row_chars;
  logic [6:0]  frame_rows;
  logic [4:0]  row_lines;
  logic [3:0]  underline;
  logic [10:0] mode;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;
  logic [5:0]  dma_gap;
  logic [3:0]  dma_len;

  crtc_out_t access_q[$];
  int        mismatch_n = 0;
  int        result_seq = 0;

  task automatic report(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_n++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report($sformatf("result %0d %s got 0x%0h want 0x%0h", result_seq, name, got, want));
  endtask

  // one bus access: update the predicted state and form the result
  function automatic crtc_out_t apply_access(input crtc_in_t acc);
    crtc_out_t  r;
    logic [7:0] v;
    logic [7:0] rd;
    int         n;
    v  = acc.data_byte;
    rd = 8'h00;
    case (acc.func)
      FUNC_WR_CMD: begin
        // a new command while parameters are owed is improper
        if (params_owed != 3'd0) status = status | STAT_IMPROPER;
        params_owed = 3'd0;
        owed_cmd    = OWED_NONE;
        if (v == CMD_RESET) begin
          owed_cmd    = OWED_RESET;
          params_owed = 3'd4;
          status      = status & ~STAT_IE;
        end else if (v == CMD_STOP) begin
          video_on = 1'b0;
          status   = status & ~STAT_VE;
        end else if (v == CMD_LIGHT_PEN) begin
          owed_cmd    = OWED_PEN;
          params_owed = 3'd2;
        end else if (v == CMD_LOAD_CURSOR) begin
          owed_cmd    = OWED_CURSOR;
          params_owed = 3'd2;
        end else if ((v & CMD_START_MASK) == CMD_START) begin
          video_on = 1'b1;
          dma_gap  = (v[4:2] == 3'd0) ? 6'd0 : {v[4:2], 3'b000} - 6'd1;
          dma_len  = 4'd1 << v[1:0];
          status   = status | STAT_IE | STAT_VE;
        end else if ((v & CMD_INT_MASK) == CMD_INT_EN) begin
          irq_on = 1'b1;
        end else if ((v & CMD_INT_MASK) == CMD_INT_DIS) begin
          irq_on = 1'b0;
        end
      end
      FUNC_WR_PARAM: begin
        if (owed_cmd == OWED_NONE) begin
          status = status | STAT_IMPROPER;
        end else begin
          if (owed_cmd == OWED_RESET) begin
            case (params_owed)
              3'd4: begin
                n = int'(v[6:0]) + 1;
                if (n > MAX_CHARS_PER_ROW) n = MAX_CHARS_PER_ROW;
                if (n > 127) n = 127;
                row_chars = 7'(n);
                mode[10]  = v[7];
              end
              3'd3: begin
                mode[5:4]  = v[7:6];
                frame_rows = {1'b0, v[5:0]} + 7'd1;
              end
              3'd2: begin
                underline = v[7:4];
                row_lines = {1'b0, v[3:0]} + 5'd1;
              end
              3'd1: begin
                mode[0]   = v[7];
                mode[1]   = v[6];
                mode[2]   = v[4];
                mode[3]   = ~v[5];
                mode[9:6] = v[3:0];
              end
              default: ;
            endcase
          end else if (owed_cmd == OWED_CURSOR) begin
            if (params_owed == 3'd2) cur_col = v;
            else if (params_owed == 3'd1) cur_row = v;
          end
          if (params_owed == 3'd0) status = status | STAT_IMPROPER;
          else params_owed = params_owed - 3'd1;
        end
      end
      FUNC_RD_STAT: begin
        rd     = status;
        status = status & STAT_KEEP;
      end
      default: ;
    endcase
    r.read_data      = rd;
    r.status_now     = status;
    r.display_on     = video_on;
    r.interrupt_on   = irq_on;
    r.chars_per_row  = row_chars;
    r.rows_per_frame = frame_rows;
    r.lines_per_row  = row_lines;
    r.underline_line = underline;
    r.cursor_address = 15'(cur_col) + 15'(cur_row) * 15'd80;
    r.burst_space    = dma_gap;
    r.burst_count    = dma_len;
    r.format_bits    = mode;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    crtc_out_t want;
    if (!rst_n) begin
      status      = 8'h00;
      owed_cmd    = OWED_NONE;
      params_owed = 3'd0;
      video_on    = 1'b0;
      irq_on      = 1'b0;
      row_chars   = 7'd80;
      frame_rows  = 7'd25;
      row_lines   = 5'd10;
      underline   = 4'd0;
      mode        = 11'd1;
      cur_col     = 8'd0;
      cur_row     = 8'd0;
      dma_gap     = 6'd0;
      dma_len     = 4'd8;
      access_q.delete();
    end else begin
      // results first: nothing accepted at this edge can already be out
      if (out_valid && !out_stall) begin
        if (access_q.size() == 0) begin
          report($sformatf("result %0d arrived with nothing expected", result_seq));
        end else begin
          want = access_q.pop_front();
          check_field("read_data", out_data.read_data, want.read_data);
          check_field("status_now", out_data.status_now, want.status_now);
          check_field("display_on", out_data.display_on, want.display_on);
          check_field("interrupt_on", out_data.interrupt_on, want.interrupt_on);
          check_field("chars_per_row", out_data.chars_per_row, want.chars_per_row);
          check_field("rows_per_frame", out_data.rows_per_frame, want.rows_per_frame);
          check_field("lines_per_row", out_data.lines_per_row, want.lines_per_row);
          check_field("underline_line", out_data.underline_line, want.underline_line);
          check_field("cursor_address", out_data.cursor_address, want.cursor_address);
          check_field("burst_space", out_data.burst_space, want.burst_space);
          check_field("burst_count", out_data.burst_count, want.burst_count);
          check_field("format_bits", out_data.format_bits, want.format_bits);
        end
        result_seq++;
      end
      if (in_valid && !in_stall) access_q.push_back(apply_access(in_data));
    end
    mismatch_count <= mismatch_n;
    results_owed   <= access_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// stimulus and verdict for the crt controller command, parameter and status port
// depends on crtc_pkg, crtc_tb_pkg, crtc_port_checker and the rtl top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import crtc_pkg::*;
  import crtc_tb_pkg::*;

  localparam int MAX_CHARS      = MAX_CHARS_PER_ROW_DEF;
  localparam int RANDOM_ITEMS   = 930;
  localparam int LONG_HOLD      = 48;    // receiver hold-off, long enough to back up the input
  localparam int DRAIN_CYCLES   = 8;     // settling margin after the last result
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no transfer on either channel

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  crtc_in_t  in_data = '0;
  logic      in_stall;
  logic      out_valid;
  crtc_out_t out_data;
  logic      out_stall = 1'b0;

  int mismatch_count;
  int results_owed;

  // idle burst odds in percent per transfer / per cycle, changed by phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // long hold-off requests from the stimulus to the receiver
  int hold_asks = 0;
  int holds_served = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crtc_command_parameter_port #(
    .MAX_CHARS_PER_ROW(MAX_CHARS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  crtc_port_checker #(
    .MAX_CHARS_PER_ROW(MAX_CHARS)
  ) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_data        (in_data),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_data       (out_data),
    .out_stall      (out_stall),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  function automatic crtc_in_t bus_access(input logic [1:0] f, input logic [7:0] d);
    crtc_in_t a;
    a.func      = f;
    a.data_byte = d;
    return a;
  endfunction

  // offer one access and hold it until the transfer happens; an optional idle
  // burst in front drops valid and scrambles the payload, which must be ignored
  task automatic send_access(input crtc_in_t acc);
    if (send_idle_pct != 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= crtc_in_t'($urandom);
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // result side: random stall bursts, plus a long hold-off whenever asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_asks != holds_served) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        holds_served++;
      end else if (recv_idle_pct != 0 && $urandom_range(1, 100) <= recv_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  initial begin
    int stuck;
    stuck = 0;
    while (stuck < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    crtc_in_t seq_q[$];
    int       sent;
    int       pick;
    int       n_params;
    bit       hold_done;
    bit       drain_done;
    sent       = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, moderate idling on both sides
    send_idle_pct = 25;
    recv_idle_pct = 25;
    // status and parameter read straight out of reset
    send_access(bus_access(FUNC_RD_STAT, 8'h00));
    send_access(bus_access(FUNC_RD_PARAM, 8'hff));
    // reset with all-ones parameters but the last: row width clamps, then a surplus parameter
    send_access(bus_access(FUNC_WR_CMD, CMD_RESET));
    send_access(bus_access(FUNC_WR_PARAM, 8'hff));
    send_access(bus_access(FUNC_WR_PARAM, 8'hff));
    send_access(bus_access(FUNC_WR_PARAM, 8'hff));
    send_access(bus_access(FUNC_WR_PARAM, 8'h00));
    send_access(bus_access(FUNC_WR_PARAM, 8'h55));
    // status read picks up the improper flag and clears it
    send_access(bus_access(FUNC_RD_STAT, 8'hff));
    // reset with minimum fields, row width one above the clamp
    send_access(bus_access(FUNC_WR_CMD, CMD_RESET));
    send_access(bus_access(FUNC_WR_PARAM, 8'h50));
    send_access(bus_access(FUNC_WR_PARAM, 8'h00));
    send_access(bus_access(FUNC_WR_PARAM, 8'h00));
    send_access(bus_access(FUNC_WR_PARAM, 8'h00));
    // cursor at its largest address
    send_access(bus_access(FUNC_WR_CMD, CMD_LOAD_CURSOR));
    send_access(bus_access(FUNC_WR_PARAM, 8'hff));
    send_access(bus_access(FUNC_WR_PARAM, 8'hff));
    // light pen cut short by start display: missing parameter
    send_access(bus_access(FUNC_WR_CMD, CMD_LIGHT_PEN));
    send_access(bus_access(FUNC_WR_PARAM, 8'h12));
    send_access(bus_access(FUNC_WR_CMD, CMD_START | 8'h1f));
    // parameter with no command pending
    send_access(bus_access(FUNC_WR_PARAM, 8'haa));
    send_access(bus_access(FUNC_WR_CMD, CMD_STOP));
    send_access(bus_access(FUNC_WR_CMD, CMD_INT_EN | 8'h05));
    send_access(bus_access(FUNC_WR_CMD, CMD_INT_DIS | 8'h03));
    send_access(bus_access(FUNC_WR_CMD, CMD_PRESET_COUNTERS));
    send_access(bus_access(FUNC_WR_CMD, CMD_START));
    send_access(bus_access(FUNC_RD_STAT, 8'h00));

    // random part: mostly whole command sequences, some broken ones and noise
    while (sent < RANDOM_ITEMS) begin
      // phases: idling, none, heavy idling, and none at the tail
      if (sent < 250) begin
        send_idle_pct = 20;
        recv_idle_pct = 15;
      end else if (sent < 450) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (sent < 800) begin
        send_idle_pct = 40;
        recv_idle_pct = 40;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // receiver holds off while we keep offering, so the input backs up
      if (!hold_done && sent >= 280) begin
        hold_asks++;
        hold_done = 1'b1;
      end
      // sender pauses until every result is back
      if (!drain_done && sent >= 600) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        drain_done = 1'b1;
      end

      seq_q.delete();
      n_params = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_RESET));
        n_params = 4;
      end else if (pick < 45) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_LOAD_CURSOR));
        n_params = 2;
      end else if (pick < 52) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_LIGHT_PEN));
        n_params = 2;
      end else if (pick < 62) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_START | 8'($urandom_range(0, 31))));
      end else if (pick < 67) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_STOP));
      end else if (pick < 72) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_INT_EN | 8'($urandom_range(0, 15))));
      end else if (pick < 77) begin
        seq_q.push_back(bus_access(FUNC_WR_CMD, CMD_INT_DIS | 8'($urandom_range(0, 15))));
      end else if (pick < 82) begin
        // any byte at all as a command
        seq_q.push_back(bus_access(FUNC_WR_CMD, 8'($urandom)));
      end else if (pick < 92) begin
        seq_q.push_back(bus_access(FUNC_RD_STAT, 8'($urandom)));
      end else if (pick < 96) begin
        seq_q.push_back(bus_access(FUNC_RD_PARAM, 8'($urandom)));
      end else begin
        seq_q.push_back(bus_access(FUNC_WR_PARAM, 8'($urandom)));
      end
      // now and then too few or too many parameters
      if (n_params != 0 && $urandom_range(0, 5) == 0) n_params = $urandom_range(0, 5);
      repeat (n_params) seq_q.push_back(bus_access(FUNC_WR_PARAM, 8'($urandom)));
      if ($urandom_range(0, 3) == 0) seq_q.push_back(bus_access(FUNC_RD_STAT, 8'($urandom)));

      foreach (seq_q[i]) send_access(seq_q[i]);
      sent += seq_q.size();
    end

    // drain: drop valid so the last transfer is counted, then wait for results
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && results_owed == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/crtc_pkg.sv
hw/rtl/crtc_in_reg.sv
hw/rtl/crtc_core.sv
hw/rtl/crtc_command_parameter_port.sv
bench/crtc_tb_pkg.sv
bench/crtc_port_checker.sv
bench/tb_top.sv
